FILE: hw/rtl/pairwise_mahalanobis_distance_assert.svh
// assertion macros for the pairwise mahalanobis distance block
`ifndef PAIRWISE_MAHALANOBIS_DISTANCE_ASSERT_SVH
`define PAIRWISE_MAHALANOBIS_DISTANCE_ASSERT_SVH
// implication checked every clock outside reset
`define PMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/pmd_pkg.sv
// package: constants, types and command structs of the distance block
`default_nettype none
package pmd_pkg;
  localparam int unsigned Features = 16;
  localparam int unsigned Rows = 1024;
  localparam int unsigned FeatW = $clog2(Features);
  localparam int unsigned RowW = $clog2(Rows);
  localparam int unsigned DataDepth = Rows * Features;
  localparam int unsigned DataAw = $clog2(DataDepth);
  localparam int unsigned MatDepth = Features * Features;
  localparam int unsigned MatAw = $clog2(MatDepth);
  localparam int unsigned AccW = 96;
  localparam logic [24:0] DistMax = 25'h1FFFFFF;

  typedef enum logic [1:0] {
    ModeLoadMat  = 2'd0,
    ModeLoadData = 2'd1,
    ModeQuery    = 2'd2,
    ModeUnused   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         row_a;
    logic [9:0]         row_b;
    logic [3:0]         feature_i;
    logic [3:0]         feature_j;
    logic signed [23:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [24:0] distance;
    logic        negative_form;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // latch input item
    logic wr_mat;
    logic wr_data;
    logic rd_a;       // read row a feature (idx) from data ram
    logic rd_b;       // read row b feature
    logic save_a;     // store read data as element a
    logic save_d;     // form d(idx) = a - b
    logic clr_acc;
    logic clr_p;
    logic rd_mat;     // read S(min,max) for i=idx_i, j=idx_j
    logic mac_p;      // p += d_i * s
    logic mac_q;      // acc += p * d_j
    logic sq_init;
    logic sq_step;
    logic [FeatW-1:0] idx_i;
    logic [FeatW-1:0] idx_j;
  } cmd_t;

  typedef struct packed {
    logic mat_ok;
    logic data_ok;
    logic query_ok;
  } status_t;
endpackage
`default_nettype wire

FILE: hw/rtl/pmd_if.sv
// valid/ready stream interface carrying one payload
`default_nettype none
interface pmd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pairwise_mahalanobis_distance.sv
// top level: pairwise mahalanobis distance over stored data table
// one item at a time; a load or an ignored item is captured and decoded, then idle again
// a query is decoded, runs the difference pass, the mac passes and the root, then
// offers the result, paced by the mac passes and the 25-step root; the next
// transaction is taken in the cycle after the result is taken; reset is asynchronous
// active low, clears control and root registers only; stores undefined until written
`default_nettype none
module pairwise_mahalanobis_distance import pmd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pmd_if.sink       in_i,
  pmd_if.source     out_o
);
  cmd_t      cmd;
  status_t   status;
  out_item_t result;
  logic      sq_done;
  in_item_t  item;

  // incoming transaction payload
  assign item = in_i.data;

  // controller: owns the handshakes and the sequencing
  pmd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .in_mode_i(item.mode),
    .status_i(status), .sq_done_i(sq_done),
    .cmd_o(cmd),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready));

  // datapath: rams, mac and root
  pmd_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item), .cmd_i(cmd),
    .status_o(status), .result_o(result), .sq_done_o(sq_done));

  assign out_o.data = result;
endmodule
`default_nettype wire

FILE: hw/rtl/pmd_ram.sv
// generic single-port ram with registered read
`default_nettype none
module pmd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/pmd_datapath.sv
// datapath: stores, difference vector, mac unit, integer square root
`default_nettype none
module pmd_datapath import pmd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  item_i,
  input  wire cmd_t      cmd_i,
  output status_t        status_o,
  output out_item_t      result_o,
  output logic           sq_done_o
);
  in_item_t item_q;
  logic signed [16:0] d_q [Features];
  logic signed [15:0] a_q;
  logic signed [47:0] p_q;
  logic signed [AccW-1:0] acc_q;
  logic [49:0] rem_q;
  logic [25:0] res_q;
  logic [5:0] sq_cnt_q;
  logic neg_q, sat_q;

  logic [DataAw-1:0] d_addr;
  logic [MatAw-1:0]  m_addr;
  logic [15:0] d_rdata, d_wdata;
  logic [23:0] m_rdata;
  logic [FeatW-1:0] r_idx, c_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
  end

  assign status_o.mat_ok   = 1'b1;
  assign status_o.data_ok  = ({22'd0, item_q.row_a} < 32'(Rows));
  assign status_o.query_ok = ({22'd0, item_q.row_a} < 32'(Rows)) &&
                             ({22'd0, item_q.row_b} < 32'(Rows));

  // data saturation to signed 16 bits
  always_comb begin
    if (item_q.load_value > 24'sd32767) d_wdata = 16'h7FFF;
    else if (item_q.load_value < -24'sd32768) d_wdata = 16'h8000;
    else d_wdata = item_q.load_value[15:0];
  end

  always_comb begin
    if (cmd_i.wr_data) d_addr = {item_q.row_a[RowW-1:0], item_q.feature_i[FeatW-1:0]};
    else if (cmd_i.rd_b) d_addr = {item_q.row_b[RowW-1:0], cmd_i.idx_i};
    else d_addr = {item_q.row_a[RowW-1:0], cmd_i.idx_i};
  end

  pmd_ram #(.Width(16), .Depth(DataDepth)) u_data_ram (
    .clk_i, .we_i(cmd_i.wr_data), .re_i(cmd_i.rd_a | cmd_i.rd_b),
    .addr_i(d_addr), .wdata_i(d_wdata), .rdata_o(d_rdata));

  always_comb begin
    r_idx = (cmd_i.idx_i < cmd_i.idx_j) ? cmd_i.idx_i : cmd_i.idx_j;
    c_idx = (cmd_i.idx_i < cmd_i.idx_j) ? cmd_i.idx_j : cmd_i.idx_i;
    if (cmd_i.wr_mat) m_addr = {item_q.feature_i[FeatW-1:0], item_q.feature_j[FeatW-1:0]};
    else m_addr = {r_idx, c_idx};
  end

  pmd_ram #(.Width(24), .Depth(MatDepth)) u_mat_ram (
    .clk_i, .we_i(cmd_i.wr_mat), .re_i(cmd_i.rd_mat),
    .addr_i(m_addr), .wdata_i(item_q.load_value), .rdata_o(m_rdata));

  logic signed [40:0] prod_p;
  logic signed [64:0] prod_q;
  logic [FeatW-1:0] mi_q;
  always_ff @(posedge clk_i) mi_q <= cmd_i.idx_i;
  assign prod_p = d_q[mi_q] * $signed(m_rdata);
  assign prod_q = p_q * d_q[cmd_i.idx_j];

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_a) a_q <= d_rdata;
    if (cmd_i.save_d) d_q[cmd_i.idx_i] <= 17'(a_q) - 17'($signed(d_rdata));
    if (cmd_i.clr_p) p_q <= '0;
    else if (cmd_i.mac_p) p_q <= p_q + 48'(prod_p);
    if (cmd_i.clr_acc) acc_q <= '0;
    else if (cmd_i.mac_q) acc_q <= acc_q + AccW'(prod_q);
  end

  // restoring square root, one result bit per step
  logic [AccW-17:0] v_sh;
  assign v_sh = acc_q[AccW-1:16];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
      res_q <= '0;
      rem_q <= '0;
      neg_q <= 1'b0;
      sat_q <= 1'b0;
    end else if (cmd_i.sq_init) begin
      sq_cnt_q <= 6'd25;
      res_q <= '0;
      rem_q <= '0;
      neg_q <= acc_q[AccW-1];
      sat_q <= !acc_q[AccW-1] && (v_sh[AccW-17:50] != '0);
    end else if (cmd_i.sq_step && sq_cnt_q != 0) begin
      sq_cnt_q <= sq_cnt_q - 6'd1;
      if ({rem_q, 2'b00} + 52'(v_sh[2*sq_cnt_q-1 -: 2]) >= {res_q, 2'b01}) begin
        rem_q <= 50'(({rem_q, 2'b00} + 52'(v_sh[2*sq_cnt_q-1 -: 2])) - {res_q, 2'b01});
        res_q <= {res_q[24:0], 1'b1};
      end else begin
        rem_q <= 50'({rem_q, 2'b00} + 52'(v_sh[2*sq_cnt_q-1 -: 2]));
        res_q <= {res_q[24:0], 1'b0};
      end
    end
  end
  assign sq_done_o = (sq_cnt_q == 0);
  assign result_o.negative_form = neg_q;
  assign result_o.distance = neg_q ? 25'd0 : (sat_q ? DistMax : res_q[24:0]);
endmodule
`default_nettype wire

FILE: hw/rtl/pmd_ctrl.sv
// controller: sequences loads and query passes over the datapath
`default_nettype none
`include "pairwise_mahalanobis_distance_assert.svh"
module pmd_ctrl import pmd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic [1:0] in_mode_i,
  input  wire status_t status_i,
  input  wire logic    sq_done_i,
  output cmd_t         cmd_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i
);
  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StDec   = 10'b0000000010,
    StRdA   = 10'b0000000100,
    StRdB   = 10'b0000001000,
    StDiff  = 10'b0000010000,
    StMat   = 10'b0000100000,
    StMac   = 10'b0001000000,
    StQ     = 10'b0010000000,
    StSqrt  = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] mode_q;
  logic [FeatW-1:0] i_q, i_d, j_q, j_d;
  logic sq_run_q;

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    cmd_o = '0;
    cmd_o.idx_i = i_q;
    cmd_o.idx_j = j_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        state_d = StIdle;
        if (mode_q == ModeLoadMat) cmd_o.wr_mat = status_i.mat_ok;
        else if (mode_q == ModeLoadData) cmd_o.wr_data = status_i.data_ok;
        else if (mode_q == ModeQuery && status_i.query_ok) begin
          i_d = '0;
          cmd_o.clr_acc = 1'b1;
          state_d = StRdA;
        end
      end
      StRdA: begin cmd_o.rd_a = 1'b1; state_d = StRdB; end
      StRdB: begin cmd_o.rd_b = 1'b1; cmd_o.save_a = 1'b1; state_d = StDiff; end
      StDiff: begin
        cmd_o.save_d = 1'b1;
        if (i_q == FeatW'(Features - 1)) begin
          i_d = '0; j_d = '0; cmd_o.clr_p = 1'b1; state_d = StMat;
        end else begin
          i_d = i_q + 1'b1; state_d = StRdA;
        end
      end
      StMat: begin cmd_o.rd_mat = 1'b1; state_d = StMac; end
      StMac: begin
        cmd_o.mac_p = 1'b1;
        if (i_q == FeatW'(Features - 1)) begin
          state_d = StQ;
        end else begin
          i_d = i_q + 1'b1; state_d = StMat;
        end
      end
      StQ: begin
        cmd_o.mac_q = 1'b1;
        cmd_o.clr_p = 1'b1;
        i_d = '0;
        if (j_q == FeatW'(Features - 1)) state_d = StSqrt;
        else begin j_d = j_q + 1'b1; state_d = StMat; end
      end
      StSqrt: begin
        if (!sq_run_q) cmd_o.sq_init = 1'b1;
        else if (sq_done_i) state_d = StOut;
        else cmd_o.sq_step = 1'b1;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q <= '0;
      i_q <= '0;
      j_q <= '0;
      sq_run_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      if (cmd_o.capture) mode_q <= in_mode_i;
      sq_run_q <= (state_q == StSqrt) && (state_d == StSqrt);
    end
  end

  `PMD_ASSERT_IMPL(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `PMD_ASSERT_IMPL(a_excl, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o))
  `PMD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule
`default_nettype wire
